/* rtl/gbf_pkg.sv */
package gbf_pkg;

  // Field and counter widths
  localparam int PIX_W       = 8;
  localparam int CNT_W       = 11;
  localparam int POS_W       = 10;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Line memory geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int LANES         = 4;
  localparam int LANE_W        = 2;
  localparam int WIN           = 5;

  // Weighted sums are at most 98 * 255, so 15 bits hold them
  localparam int SUM_W = 15;

  // Divide by 98: multiply by ceil(2^21 / 98) and shift; exact for sums < 2^21 / 48
  localparam int          RECIP_W  = 15;
  localparam int          RECIP_SH = 21;
  localparam logic [14:0] RECIP_98 = 15'd21400;
  localparam int          DIV16_SH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // Kernel weights, [row][col] from the top-left corner of the window
  typedef logic [3:0] weight_t;
  localparam weight_t K5 [WIN][WIN] = '{
    '{4'd1, 4'd2, 4'd3,  4'd2, 4'd1},
    '{4'd2, 4'd8, 4'd6,  4'd6, 4'd2},
    '{4'd3, 4'd8, 4'd10, 4'd8, 4'd3},
    '{4'd2, 4'd8, 4'd6,  4'd6, 4'd2},
    '{4'd1, 4'd2, 4'd3,  4'd2, 4'd1}
  };
  localparam weight_t K3 [3][3] = '{
    '{4'd1, 4'd2, 4'd1},
    '{4'd2, 4'd4, 4'd2},
    '{4'd1, 4'd2, 4'd1}
  };

  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;
  typedef logic [LANES-1:0][PIX_W-1:0] line_word_t;

  // Per-item tag that follows a result through the datapath
  typedef struct packed {
    logic             valid;
    logic             ksel;
    logic [POS_W-1:0] crow;
    logic [POS_W-1:0] ccol;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] blurred;
    logic [POS_W-1:0] crow;
    logic [POS_W-1:0] ccol;
    logic             last;
  } res_t;

endpackage

/* rtl/gbf_linebuf.sv */
module gbf_linebuf #(
  parameter int MAX_WIDTH = gbf_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [$clog2(MAX_WIDTH)-1:0]     addr,
  input  logic [gbf_pkg::LANE_W-1:0]       lane,
  input  logic [gbf_pkg::PIX_W-1:0]        wdata,
  output gbf_pkg::line_word_t              rdata
);
  import gbf_pkg::*;

  // One word per column, one byte lane per buffered row
  line_word_t mem [MAX_WIDTH];

  // Read-first: the returned word holds the column before this pixel lands
  always_ff @(posedge clk) begin
    if (en) begin
      rdata           <= mem[addr];
      mem[addr][lane] <= wdata;
    end
  end

endmodule

/* rtl/gbf_conv.sv */
module gbf_conv (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  gbf_pkg::win_t  win,
  input  gbf_pkg::meta_t meta_in,
  output gbf_pkg::res_t  res
);
  import gbf_pkg::*;

  logic [SUM_W-1:0]         rs5 [WIN];
  logic [SUM_W-1:0]         rs3 [WIN];
  logic [SUM_W-1:0]         rsum [WIN];
  meta_t                    meta_a;
  logic [SUM_W-1:0]         total;
  meta_t                    meta_b;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SUM_W-1:0]         total_c;
  meta_t                    meta_c;

  // Weighted row sums for both kernels; the 3x3 kernel sits in the bottom-right corner
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      rs5[i] = '0;
      rs3[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        rs5[i] = rs5[i] + SUM_W'(K5[i][j]) * SUM_W'(win[i][j]);
        if (i >= 2 && j >= 2) begin
          rs3[i] = rs3[i] + SUM_W'(K3[i-2][j-2]) * SUM_W'(win[i][j]);
        end
      end
    end
  end

  // Stage A: register row sums of the selected kernel
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_a <= '0;
    end else if (en) begin
      meta_a <= meta_in;
      for (int i = 0; i < WIN; i++) begin
        rsum[i] <= meta_in.ksel ? rs5[i] : rs3[i];
      end
    end
  end

  // Stage B: add the row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_b <= '0;
    end else if (en) begin
      meta_b <= meta_a;
      total  <= rsum[0] + rsum[1] + rsum[2] + rsum[3] + rsum[4];
    end
  end

  // Stage C: reciprocal multiply for the divide by 98
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_c <= '0;
    end else if (en) begin
      meta_c  <= meta_b;
      total_c <= total;
      prod    <= (SUM_W+RECIP_W)'(total) * (SUM_W+RECIP_W)'(RECIP_98);
    end
  end

  // Output register: pick the quotient for the active kernel
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (en) begin
      res.valid   <= meta_c.valid;
      res.blurred <= meta_c.ksel ? prod[RECIP_SH +: PIX_W] : total_c[DIV16_SH +: PIX_W];
      res.crow    <= meta_c.crow;
      res.ccol    <= meta_c.ccol;
      res.last    <= meta_c.last;
    end
  end

endmodule

/* rtl/gaussian_blur_filter_unit.sv */
// Gaussian blur on a raster stream of 8-bit grayscale pixels.
// Input stream (s_axis): one pixel per transaction, tuser marks the first
// pixel of a frame and forces row 0, column 0. Output stream (m_axis): one
// blurred value per interior center, tagged with its row and column; tlast
// marks the final interior pixel of the frame. Border pixels give no output.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 width,
// 1 height, 2 kernel select: 0 is 3x3 / 16, 1 is 5x5 / 98). Write only
// while the pipeline holds no pending pixel.
// Throughput: one pixel per clock while the output does not stall. The line memory is read and written at
// the same column in the accept cycle, so every pixel can follow the last.
// Pipeline: the pixel that completes a window passes the stage 1 register
// (the memory read shares the accept edge), then the window, row sums,
// total, reciprocal multiply and output registers.
// Stall: when m_axis_tready is low with a result waiting, the whole
// pipeline holds and s_axis_tready drops in the same cycle.
// Reset: counters, configuration, window and tags clear; data registers keep their values;
// the line memory is left as is and is fully rewritten before any of it feeds a result.
module gaussian_blur_filter_unit #(
  parameter int MAX_WIDTH = gbf_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_axis_tdata: [7:0] pixel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gbf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: [0] frame_start
  input  logic                               s_axis_tuser,
  // m_axis_tdata: [7:0] blurred, [17:8] center_row, [27:18] center_col, [31:28] zero
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gbf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we,
  input  logic [gbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbf_pkg::CFG_W-1:0]          cfg_data
);
  import gbf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic              kernel_select;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  col_count;

  logic              adv;
  logic              acc;
  logic [CNT_W-1:0]  r;
  logic [CNT_W-1:0]  c;
  logic [CNT_W:0]    w_lim;
  logic [CNT_W-1:0]  h_lim;
  logic              col_end;
  logic              row_end;
  logic [AW-1:0]     col_idx;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  half;
  logic              emit;

  line_word_t        rd_word;
  logic              v1;
  logic [PIX_W-1:0]  pix1;
  logic [LANE_W-1:0] lane1;
  meta_t             meta1;
  win_t              window;
  win_t              window_next;
  meta_t             meta2;
  res_t              res;

  // Whole pipeline moves unless a result waits at the output
  assign adv           = !res.valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      image_height  <= IMAGE_HEIGHT_RST;
      kernel_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_KERNEL_SELECT: kernel_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and its effective frame size
  always_comb begin
    r = s_axis_tuser ? '0 : row_count;
    c = s_axis_tuser ? '0 : col_count;
    if (image_width == '0) begin
      w_lim = (CNT_W+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_lim = (CNT_W+1)'(MAX_WIDTH);
    end else begin
      w_lim = {1'b0, image_width};
    end
    h_lim   = (image_height == '0) ? CNT_W'(1) : image_height;
    col_end = ({1'b0, c} + (CNT_W+1)'(1)) >= w_lim;
    row_end = ({1'b0, r} + (CNT_W+1)'(1)) >= {1'b0, h_lim};
    col_idx = (32'(c) < MAX_WIDTH) ? AW'(c) : '0;
    half    = kernel_select ? CNT_W'(2) : CNT_W'(1);
    span    = kernel_select ? CNT_W'(4) : CNT_W'(2);
    emit    = (r >= span) && (c >= span);
  end

  // Advance the raster counters on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : r + CNT_W'(1);
      end else begin
        col_count <= c + CNT_W'(1);
        row_count <= r;
      end
    end
  end

  gbf_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk   (clk),
    .en    (acc),
    .addr  (col_idx),
    .lane  (r[LANE_W-1:0]),
    .wdata (s_axis_tdata[PIX_W-1:0]),
    .rdata (rd_word)
  );

  // Stage 1: hold the pixel and its tag while the memory word arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      meta1 <= '0;
    end else if (adv) begin
      v1          <= acc;
      meta1.valid <= acc && emit;
      meta1.ksel  <= kernel_select;
      meta1.crow  <= POS_W'(r - half);
      meta1.ccol  <= POS_W'(c - half);
      meta1.last  <= row_end && col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix1  <= s_axis_tdata[PIX_W-1:0];
      lane1 <= r[LANE_W-1:0];
    end
  end

  // Shift the window left and load the new column, oldest row on top
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN-1; j++) begin
        window_next[i][j] = window[i][j+1];
      end
    end
    for (int i = 0; i < LANES; i++) begin
      window_next[i][WIN-1] = rd_word[lane1 + LANE_W'(i)];
    end
    window_next[WIN-1][WIN-1] = pix1;
  end

  // Stage 2: the window register carries the item into the kernel datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      meta2  <= '0;
    end else if (adv) begin
      if (v1) begin
        window <= window_next;
      end
      meta2 <= meta1;
    end
  end

  gbf_conv u_conv (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .win     (window),
    .meta_in (meta2),
    .res     (res)
  );

  assign m_axis_tvalid = res.valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - PIX_W - 2*POS_W)'(0), res.ccol, res.crow, res.blurred};
  assign m_axis_tlast  = res.last;

  // A waiting result must block new input in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Every accepted pixel reaches stage 1 on the next edge
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted pixel lost before stage 1");

  // Window holds while the pipeline is stalled
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(window))
    else $error("window changed during stall");

endmodule
